/* design/assert_macros.svh */
// Assertion macros used by the fixed-point ALU top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with reset masking; clk and rst_n must be in scope.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Implication form of the clocked assertion.
`define ASSERT_IMPL(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

/* design/fpa_pkg.sv */
// Package with operation codes and the side-band record of the fixed-point ALU.
package fpa_pkg;

    localparam logic [3:0] ACT_ADD   = 4'd0;
    localparam logic [3:0] ACT_SUB   = 4'd1;
    localparam logic [3:0] ACT_MUL   = 4'd2;
    localparam logic [3:0] ACT_DIV   = 4'd3;
    localparam logic [3:0] ACT_MIN   = 4'd4;
    localparam logic [3:0] ACT_MAX   = 4'd5;
    localparam logic [3:0] ACT_INC   = 4'd6;
    localparam logic [3:0] ACT_DEC   = 4'd7;
    localparam logic [3:0] ACT_TOINT = 4'd8;

    // Radix-2 quotient bits resolved by each divider stage.
    localparam int unsigned DIV_STEP = 4;

    // Everything that rides alongside the divider data.
    typedef struct packed {
        logic signed [31:0] res;
        logic               lt;
        logic               eq;
        logic               gt;
        logic               dz;
        logic               is_div;
        logic               qneg;
    } side_t;

endpackage

/* design/fpa_in_if.sv */
// Input channel of the fixed-point ALU: action code and two operands.
interface fpa_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         action;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, action, operand_a, operand_b, input ready);
    modport sink   (input valid, action, operand_a, operand_b, output ready);
endinterface

/* design/fpa_out_if.sv */
// Output channel of the fixed-point ALU: result word and flags.
interface fpa_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result;
    logic               a_less_b;
    logic               a_equal_b;
    logic               a_greater_b;
    logic               divide_by_zero;

    modport source (output valid, result, a_less_b, a_equal_b, a_greater_b,
                    divide_by_zero, input ready);
    modport sink   (input valid, result, a_less_b, a_equal_b, a_greater_b,
                    divide_by_zero, output ready);
endinterface

/* design/fixed_point_alu.sv */
// Top level of the pipelined signed 32-bit fixed-point ALU.
// Usage: the req channel takes one word per operation: an action code
// (add, subtract, multiply, divide, min, max, increment, decrement, to
// integer) and two raw fixed-point operands with FRAC_BITS fraction bits.
// The rsp channel returns one word per operation: the wrapped 32-bit result
// and the compare flags of operand_a against operand_b, plus a divide by zero
// flag. A word moves when valid and ready are both high at a clock edge.
// Every operation takes the same path, so results leave in order: the front
// end, NSTG divider stages, where NSTG = ceil((32 + FRAC_BITS) / 4), each
// resolving four quotient bits, and the output register. One word can enter
// in every clock cycle while req.ready stays high.
// The multiplier is a single 32 by 32 product registered in the first stage.
// When the receiver stalls, words close the gaps between them and then the
// pipeline holds; req.ready drops only once every stage is full.
// The asynchronous reset clears all valid bits; no word is in flight after it.
`include "assert_macros.svh"

module fixed_point_alu #(
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    fpa_in_if.sink     req,
    fpa_out_if.source  rsp
);

    localparam int unsigned DW   = 32 + FRAC_BITS;
    localparam int unsigned NSTG = (DW + fpa_pkg::DIV_STEP - 1) / fpa_pkg::DIV_STEP;
    localparam int unsigned DWP  = NSTG * fpa_pkg::DIV_STEP;

    // Stage links: index 0 is the front end output, NSTG feeds the back end.
    logic            lvalid [NSTG+1];
    logic            lready [NSTG+1];
    fpa_pkg::side_t  lside  [NSTG+1];
    logic [31:0]     lrem   [NSTG+1];
    logic [DWP-1:0]  ldq    [NSTG+1];
    logic [31:0]     ldvs   [NSTG+1];

    fpa_front #(
        .FRAC_BITS (FRAC_BITS),
        .DWP       (DWP)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .out_valid (lvalid[0]),
        .out_ready (lready[0]),
        .out_side  (lside[0]),
        .out_dq    (ldq[0]),
        .out_dvs   (ldvs[0])
    );

    // The partial remainder starts at zero.
    assign lrem[0] = '0;

    for (genvar s = 0; s < NSTG; s++)
    begin : g_div
        fpa_div_stage #(
            .DWP (DWP)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (lvalid[s]),
            .in_ready  (lready[s]),
            .in_side   (lside[s]),
            .in_rem    (lrem[s]),
            .in_dq     (ldq[s]),
            .in_dvs    (ldvs[s]),
            .out_valid (lvalid[s+1]),
            .out_ready (lready[s+1]),
            .out_side  (lside[s+1]),
            .out_rem   (lrem[s+1]),
            .out_dq    (ldq[s+1]),
            .out_dvs   (ldvs[s+1])
        );
    end

    fpa_back #(
        .DWP (DWP)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (lvalid[NSTG]),
        .in_ready (lready[NSTG]),
        .in_side  (lside[NSTG]),
        .in_dq    (ldq[NSTG]),
        .rsp      (rsp)
    );

    // Exactly one compare flag describes each pair of operands.
    `ASSERT_IMPL(a_flags_onehot, rsp.valid,
        $onehot({rsp.a_less_b, rsp.a_equal_b, rsp.a_greater_b}),
        "compare flags are not one-hot")
    // A zero divisor forces a zero result and means the operands differ unless both zero.
    `ASSERT_IMPL(a_dz_zero, rsp.valid && rsp.divide_by_zero, rsp.result == 32'sd0,
        "divide by zero with a nonzero result")
    // A draining receiver never blocks the sender.
    `ASSERT_IMPL(a_ready_chain, rsp.ready, req.ready,
        "input stalled while the output drains")

endmodule

/* design/fpa_front.sv */
// Front end: decode, simple operations, multiply and divider setup in two stages.
module fpa_front #(
    parameter int unsigned FRAC_BITS = 8,
    parameter int unsigned DWP       = 40
) (
    input  logic                clk,
    input  logic                rst_n,
    fpa_in_if.sink              req,
    output logic                out_valid,
    input  logic                out_ready,
    output fpa_pkg::side_t      out_side,
    output logic [DWP-1:0]      out_dq,
    output logic [31:0]         out_dvs
);

    // Stage one registers.
    logic                  v1_reg;
    fpa_pkg::side_t        side1_reg, side1_next;
    logic signed [63:0]    prod_reg, prod_next;
    logic                  mul1_reg, mul1_next;
    logic [DWP-1:0]        dq1_reg, dq1_next;
    logic [31:0]           dvs1_reg, dvs1_next;
    // Stage two registers.
    logic                  v2_reg;
    fpa_pkg::side_t        side2_reg, side2_next;
    logic [DWP-1:0]        dq2_reg;
    logic [31:0]           dvs2_reg;

    logic                  rdy1, rdy2;
    logic signed [31:0]    a, b;
    logic [31:0]           abs_a;
    logic signed [63:0]    prod_sh;

    assign a = req.operand_a;
    assign b = req.operand_b;
    assign rdy2 = !v2_reg || out_ready;
    assign rdy1 = !v1_reg || rdy2;
    assign req.ready = rdy1;

    always_comb
    begin
        side1_next        = '0;
        side1_next.lt     = a < b;
        side1_next.eq     = a == b;
        side1_next.gt     = a > b;
        side1_next.is_div = req.action == fpa_pkg::ACT_DIV;
        side1_next.dz     = side1_next.is_div && (b == 32'sd0);
        side1_next.qneg   = a[31] ^ b[31];
        mul1_next         = req.action == fpa_pkg::ACT_MUL;
        unique case (req.action)
            fpa_pkg::ACT_ADD:   side1_next.res = a + b;
            fpa_pkg::ACT_SUB:   side1_next.res = a - b;
            fpa_pkg::ACT_MIN:   side1_next.res = (a < b) ? a : b;
            fpa_pkg::ACT_MAX:   side1_next.res = (a > b) ? a : b;
            fpa_pkg::ACT_INC:   side1_next.res = a + 32'sd1;
            fpa_pkg::ACT_DEC:   side1_next.res = a - 32'sd1;
            fpa_pkg::ACT_TOINT: side1_next.res = a >>> FRAC_BITS;
            default:            side1_next.res = '0;
        endcase
        prod_next = 64'(a) * 64'(b);
        abs_a     = a[31] ? 32'(-a) : a;
        dvs1_next = b[31] ? 32'(-b) : b;
        dq1_next  = DWP'(abs_a) << FRAC_BITS;
    end

    always_comb
    begin
        prod_sh    = prod_reg >>> FRAC_BITS;
        side2_next = side1_reg;
        if (mul1_reg)
        begin
            side2_next.res = prod_sh[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= req.valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && req.valid)
        begin
            side1_reg <= side1_next;
            prod_reg  <= prod_next;
            mul1_reg  <= mul1_next;
            dq1_reg   <= dq1_next;
            dvs1_reg  <= dvs1_next;
        end
        if (rdy2 && v1_reg)
        begin
            side2_reg <= side2_next;
            dq2_reg   <= dq1_reg;
            dvs2_reg  <= dvs1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_side  = side2_reg;
    assign out_dq    = dq2_reg;
    assign out_dvs   = dvs2_reg;

endmodule

/* design/fpa_div_stage.sv */
// One divider stage: a few restoring division steps on the magnitudes.
module fpa_div_stage #(
    parameter int unsigned DWP = 40
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  fpa_pkg::side_t  in_side,
    input  logic [31:0]     in_rem,
    input  logic [DWP-1:0]  in_dq,
    input  logic [31:0]     in_dvs,
    output logic            out_valid,
    input  logic            out_ready,
    output fpa_pkg::side_t  out_side,
    output logic [31:0]     out_rem,
    output logic [DWP-1:0]  out_dq,
    output logic [31:0]     out_dvs
);

    logic            v_reg;
    fpa_pkg::side_t  side_reg;
    logic [31:0]     rem_reg, rem_next;
    logic [DWP-1:0]  dq_reg, dq_next;
    logic [31:0]     dvs_reg;
    logic [32:0]     r;

    assign in_ready = !v_reg || out_ready;

    // The remainder stays below the divisor, so 33 bits hold the shifted value.
    always_comb
    begin
        r       = {1'b0, in_rem};
        dq_next = in_dq;
        for (int i = 0; i < int'(fpa_pkg::DIV_STEP); i++)
        begin
            r       = {r[31:0], dq_next[DWP-1]};
            dq_next = {dq_next[DWP-2:0], 1'b0};
            if (r >= {1'b0, in_dvs})
            begin
                r          = r - {1'b0, in_dvs};
                dq_next[0] = 1'b1;
            end
        end
        rem_next = r[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            side_reg <= in_side;
            rem_reg  <= rem_next;
            dq_reg   <= dq_next;
            dvs_reg  <= in_dvs;
        end
    end

    assign out_valid = v_reg;
    assign out_side  = side_reg;
    assign out_rem   = rem_reg;
    assign out_dq    = dq_reg;
    assign out_dvs   = dvs_reg;

endmodule

/* design/fpa_back.sv */
// Output stage: quotient sign fix-up, result select and the output register.
module fpa_back #(
    parameter int unsigned DWP = 40
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  fpa_pkg::side_t  in_side,
    input  logic [DWP-1:0]  in_dq,
    fpa_out_if.source       rsp
);

    logic                v_reg;
    logic signed [31:0]  res_reg, res_next;
    logic                lt_reg, eq_reg, gt_reg, dz_reg;
    logic [31:0]         q;

    assign in_ready = !v_reg || rsp.ready;

    always_comb
    begin
        q = in_dq[31:0];
        if (!in_side.is_div)
        begin
            res_next = in_side.res;
        end
        else if (in_side.dz)
        begin
            res_next = '0;
        end
        else
        begin
            res_next = in_side.qneg ? 32'(-q) : q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            res_reg <= res_next;
            lt_reg  <= in_side.lt;
            eq_reg  <= in_side.eq;
            gt_reg  <= in_side.gt;
            dz_reg  <= in_side.dz;
        end
    end

    assign rsp.valid          = v_reg;
    assign rsp.result         = res_reg;
    assign rsp.a_less_b       = lt_reg;
    assign rsp.a_equal_b      = eq_reg;
    assign rsp.a_greater_b    = gt_reg;
    assign rsp.divide_by_zero = dz_reg;

endmodule

/* test/fixed_point_alu_test.sv */
// Self-checking testbench for the fixed-point ALU: directed table, then random words.
module fixed_point_alu_test;

    localparam int unsigned FRAC = 8;
    // Pipeline depth: NSTG divider stages plus the front-end and output stages.
    localparam int unsigned LATENCY = (32 + FRAC + 3) / 4 + 3;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned RANDOM_WORDS = 1200;
    localparam int unsigned HOLD_CYCLES = 60;
    localparam int unsigned TABLE_ROWS = 23;

    // One expected response word.
    typedef struct packed {
        logic signed [31:0] result;
        logic               lt;
        logic               eq;
        logic               gt;
        logic               dz;
    } alu_rsp_t;

    // One row of the directed table; has_value marks rows whose result is typed in.
    typedef struct {
        logic [3:0]         action;
        logic signed [31:0] a;
        logic signed [31:0] b;
        bit                 has_value;
        logic signed [31:0] value;
        bit                 dz;
    } table_row_t;

    logic clk;
    logic rst_n;

    fpa_in_if  req();
    fpa_out_if rsp();

    fixed_point_alu #(.FRAC_BITS(FRAC)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    alu_rsp_t pending_rsp[$];
    int unsigned mismatches;
    int unsigned idle_cycles;

    // Idle rates in percent for the sender and the receiver, changed by phase.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          recv_hold;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Computes the expected response of one operation.
    function automatic alu_rsp_t alu_predict(logic [3:0] action, logic signed [31:0] a,
                                             logic signed [31:0] b);
        alu_rsp_t r;
        logic signed [63:0] wide_a;
        logic signed [63:0] wide_b;
        logic signed [63:0] prod;
        logic signed [63:0] quot;
        wide_a = a;
        wide_b = b;
        r = '0;
        r.lt = (a < b);
        r.eq = (a == b);
        r.gt = (a > b);
        case (action)
            fpa_pkg::ACT_ADD:   r.result = a + b;
            fpa_pkg::ACT_SUB:   r.result = a - b;
            fpa_pkg::ACT_MUL:
            begin
                prod = wide_a * wide_b;
                prod = prod >>> FRAC;
                r.result = prod[31:0];
            end
            fpa_pkg::ACT_DIV:
            begin
                if (b == 0)
                begin
                    r.dz = 1'b1;
                end
                else
                begin
                    // SystemVerilog signed division truncates toward zero.
                    quot = (wide_a <<< FRAC) / wide_b;
                    r.result = quot[31:0];
                end
            end
            fpa_pkg::ACT_MIN:   r.result = (a < b) ? a : b;
            fpa_pkg::ACT_MAX:   r.result = (a > b) ? a : b;
            fpa_pkg::ACT_INC:   r.result = a + 32'sd1;
            fpa_pkg::ACT_DEC:   r.result = a - 32'sd1;
            fpa_pkg::ACT_TOINT: r.result = a >>> FRAC;
            default:            r.result = '0;
        endcase
        return r;
    endfunction

    // Drives one request word and waits until the block takes it.
    task automatic send_word(logic [3:0] action, logic signed [31:0] a, logic signed [31:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.action    <= action;
        req.operand_a <= a;
        req.operand_b <= b;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        pending_rsp.push_back(alu_predict(action, a, b));
        // The next call either raises valid again or idles, so only one
        // assignment lands on valid at each edge.
    endtask

    task automatic finish_sending();
        req.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Biased random operand: often an extreme or a small value.
    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return $signed($urandom_range(1023)) - 512;
            4: return $signed($urandom_range(65535)) - 32768;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_random(int unsigned count);
        logic [3:0]         action;
        logic signed [31:0] a;
        logic signed [31:0] b;
        for (int unsigned i = 0; i < count; i++)
        begin
            // Mostly legal codes; unused codes 9 to 15 now and then.
            action = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 9))
                                               : 4'($urandom_range(8));
            a = pick_operand();
            b = ($urandom_range(7) == 0) ? a : pick_operand();
            send_word(action, a, b);
        end
    endtask

    // Receiver: random back-pressure plus an optional long hold.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            rsp.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Checks each accepted response against the oldest expectation.
    always @(posedge clk)
    begin
        alu_rsp_t got;
        alu_rsp_t want;
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (rsp.valid && rsp.ready)
            begin
                got.result = rsp.result;
                got.lt     = rsp.a_less_b;
                got.eq     = rsp.a_equal_b;
                got.gt     = rsp.a_greater_b;
                got.dz     = rsp.divide_by_zero;
                if (pending_rsp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected response word: result %h", got.result);
                    end
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: want res %h lt %b eq %b gt %b dz %b",
                                     want.result, want.lt, want.eq, want.gt, want.dz);
                            $display("          got  res %h lt %b eq %b gt %b dz %b",
                                     got.result, got.lt, got.eq, got.gt, got.dz);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Long receiver hold, counted in its own process, started once.
    task automatic hold_receiver();
        recv_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_hold = 1'b0;
    endtask

    table_row_t directed[TABLE_ROWS] = '{
        '{fpa_pkg::ACT_ADD,   32'sh7fff_ffff, 32'sd1,         1'b1, 32'sh8000_0000, 1'b0},
        '{fpa_pkg::ACT_SUB,   32'sh8000_0000, 32'sd1,         1'b1, 32'sh7fff_ffff, 1'b0},
        '{fpa_pkg::ACT_MUL,   32'sd256,       32'sd256,       1'b1, 32'sd256,       1'b0},
        '{fpa_pkg::ACT_MUL,   32'sh8000_0000, 32'sh8000_0000, 1'b0, 32'sd0,         1'b0},
        '{fpa_pkg::ACT_MUL,   32'sh7fff_ffff, 32'sh8000_0000, 1'b0, 32'sd0,         1'b0},
        '{fpa_pkg::ACT_MUL,   -32'sd1,        32'sd1,         1'b1, -32'sd1,        1'b0},
        '{fpa_pkg::ACT_DIV,   32'sd256,       32'sd0,         1'b1, 32'sd0,         1'b1},
        '{fpa_pkg::ACT_DIV,   32'sh8000_0000, 32'sd0,         1'b1, 32'sd0,         1'b1},
        '{fpa_pkg::ACT_DIV,   32'sd512,       32'sd256,       1'b1, 32'sd512,       1'b0},
        '{fpa_pkg::ACT_DIV,   32'sh8000_0000, -32'sd1,        1'b0, 32'sd0,         1'b0},
        '{fpa_pkg::ACT_DIV,   -32'sd7,        32'sd3000,      1'b0, 32'sd0,         1'b0},
        '{fpa_pkg::ACT_DIV,   32'sh7fff_ffff, 32'sh8000_0000, 1'b0, 32'sd0,         1'b0},
        '{fpa_pkg::ACT_MIN,   32'sd5,         32'sd5,         1'b1, 32'sd5,         1'b0},
        '{fpa_pkg::ACT_MIN,   32'sh8000_0000, 32'sh7fff_ffff, 1'b1, 32'sh8000_0000, 1'b0},
        '{fpa_pkg::ACT_MAX,   32'sh8000_0000, 32'sh7fff_ffff, 1'b1, 32'sh7fff_ffff, 1'b0},
        '{fpa_pkg::ACT_MAX,   -32'sd3,        -32'sd3,        1'b1, -32'sd3,        1'b0},
        '{fpa_pkg::ACT_INC,   32'sh7fff_ffff, 32'sd9,         1'b1, 32'sh8000_0000, 1'b0},
        '{fpa_pkg::ACT_DEC,   32'sh8000_0000, 32'sd9,         1'b1, 32'sh7fff_ffff, 1'b0},
        '{fpa_pkg::ACT_TOINT, -32'sd1,        32'sd0,         1'b1, -32'sd1,        1'b0},
        '{fpa_pkg::ACT_TOINT, 32'sh7fff_ffff, 32'sd0,         1'b1, 32'sh007f_ffff, 1'b0},
        '{fpa_pkg::ACT_TOINT, 32'sh8000_0000, 32'sd0,         1'b1, 32'shff80_0000, 1'b0},
        '{4'd9,               32'sd1,         32'sd2,         1'b1, 32'sd0,         1'b0},
        '{4'd15,              -32'sd1,        -32'sd1,        1'b1, 32'sd0,         1'b0}
    };

    initial
    begin
        alu_rsp_t want;
        rst_n         = 1'b0;
        req.valid     = 1'b0;
        req.action    = fpa_pkg::ACT_ADD;
        req.operand_a = '0;
        req.operand_b = '0;
        mismatches    = 0;
        idle_cycles   = 0;
        recv_hold     = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: typed-in results are cross-checked against the predictor.
        foreach (directed[i])
        begin
            if (directed[i].has_value)
            begin
                want = alu_predict(directed[i].action, directed[i].a, directed[i].b);
                if (want.result !== directed[i].value || want.dz !== directed[i].dz)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("table row %0d: typed %h, predicted %h",
                                 i, directed[i].value, want.result);
                    end
                end
            end
            send_word(directed[i].action, directed[i].a, directed[i].b);
        end

        // Long receiver hold while the sender keeps offering words.
        fork
            hold_receiver();
            run_random(80);
        join

        send_idle_pct = 28;
        recv_idle_pct = 76;
        run_random(RANDOM_WORDS / 3);
        send_idle_pct = 76;
        recv_idle_pct = 28;
        run_random(RANDOM_WORDS / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(RANDOM_WORDS / 3);
        finish_sending();

        while (pending_rsp.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 4) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

/* sim.f */
+incdir+design
design/fpa_pkg.sv
design/fpa_in_if.sv
design/fpa_out_if.sv
design/fpa_front.sv
design/fpa_div_stage.sv
design/fpa_back.sv
design/fixed_point_alu.sv
test/fixed_point_alu_test.sv
